// ===== rtl/sbh_pkg.sv =====
// Shared types, constants and round functions of the byte-stream hasher.
`timescale 1ns / 1ps
package sbh_pkg;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;

	typedef struct packed {
		logic       round;
		logic       shift;
		logic       vload;
		logic       wpush;
		logic       wsel_mem;
		logic [5:0] kidx;
	} core_ctrl_t;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		case (i)
			3'd0: init_hash = 32'h6a09e667;
			3'd1: init_hash = 32'hbb67ae85;
			3'd2: init_hash = 32'h3c6ef372;
			3'd3: init_hash = 32'ha54ff53a;
			3'd4: init_hash = 32'h510e527f;
			3'd5: init_hash = 32'h9b05688c;
			3'd6: init_hash = 32'h1f83d9ab;
			default: init_hash = 32'h5be0cd19;
		endcase
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		case (t)
			6'd0:  round_k = 32'h428a2f98;
			6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;
			6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;
			6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;
			6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;
			6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;
			6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;
			6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;
			6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;
			6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;
			6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;
			6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;
			6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;
			6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;
			6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;
			6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;
			6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;
			6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;
			6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;
			6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;
			6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;
			6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;
			6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;
			6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;
			6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;
			6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;
			6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;
			6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;
			6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;
			6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;
			6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;
			6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;
			default: round_k = 32'hc67178f2;
		endcase
	endfunction

endpackage

// ===== rtl/sha256_byte_stream_hasher.sv =====
// Streaming SHA-256 hasher top level: byte packing, padding, sequencing, digest out.
// A byte that neither completes a block nor is last is taken with no hold. A full block
// holds off input while it is compressed: hash words read, 64 rounds, then add-back.
// Last item: padding runs one byte per cycle to the block end (up to 72 bytes over two
// blocks), then eight digest words leave by the RAM read port, one read in flight at a time.
// Reset clears control; the hash-word RAM is not cleared, a first-block flag feeds the IV.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        digest_last
);

	localparam logic [2:0] ST_ABSORB = 3'd0;
	localparam logic [2:0] ST_PAD    = 3'd1;
	localparam logic [2:0] ST_LOAD   = 3'd2;
	localparam logic [2:0] ST_ROUND  = 3'd3;
	localparam logic [2:0] ST_ADD    = 3'd4;
	localparam logic [2:0] ST_OUT    = 3'd5;

	logic [2:0]  state_q;
	logic [5:0]  cnt_q;
	logic [5:0]  fill_q;
	logic [23:0] word_q;
	logic [60:0] count_q;
	logic        pad_q;
	logic        pad_first_q;
	logic        len_ok_q;
	logic        pad_done_q;
	logic        first_block_q;
	logic        rd_pend_q;
	logic        out_valid_q;
	logic [31:0] digest_word_q;
	logic [2:0]  word_index_q;
	logic        digest_last_q;

	logic        accept;
	logic        len_phase;
	logic [63:0] len_bits;
	logic [5:0]  len_pos;
	logic [7:0]  pad_byte;
	logic        push_en;
	logic [7:0]  push_byte;
	logic [2:0]  cnt_m1;
	logic        load_out;

	logic        blk_we;
	logic        blk_re;
	logic [3:0]  blk_raddr;
	logic [31:0] blk_rdata;
	logic        h_we;
	logic        h_re;
	logic [2:0]  h_raddr;
	logic [31:0] h_wdata;
	logic [31:0] h_rdata;
	logic [31:0] h_base;
	logic [31:0] load_word;
	logic [31:0] v0;
	sbh_pkg::core_ctrl_t ctrl;

	assign in_stall = (state_q != ST_ABSORB);
	assign accept   = in_valid && !in_stall;

	// Length bytes go out most significant first over the last eight slots.
	assign len_bits  = {count_q, 3'b000};
	assign len_pos   = {~fill_q[2:0], 3'b000};
	assign len_phase = !pad_first_q && len_ok_q && (fill_q >= sbh_pkg::LEN_START);
	assign pad_byte  = pad_first_q ? sbh_pkg::PAD_MARK :
		(len_phase ? len_bits[len_pos +: 8] : 8'h00);

	assign push_en   = (accept && byte_present) || (state_q == ST_PAD);
	assign push_byte = (state_q == ST_PAD) ? pad_byte : data_byte;
	assign blk_we    = push_en && (fill_q[1:0] == 2'b11);

	assign cnt_m1    = cnt_q[2:0] - 3'd1;
	assign h_base    = first_block_q ? sbh_pkg::init_hash(cnt_m1) : h_rdata;
	assign load_word = h_base;
	assign h_wdata   = h_base + v0;
	assign load_out  = (state_q == ST_OUT) && rd_pend_q && (!out_valid_q || !out_stall);

	always_comb begin
		ctrl      = '0;
		blk_re    = 1'b0;
		blk_raddr = 4'd0;
		h_re      = 1'b0;
		h_we      = 1'b0;
		h_raddr   = cnt_q[2:0];
		case (state_q)
			ST_LOAD: begin
				h_re       = (cnt_q < 6'd8);
				ctrl.shift = (cnt_q != 6'd0);
				ctrl.vload = (cnt_q != 6'd0);
				blk_re     = (cnt_q == 6'd7) || (cnt_q == 6'd8);
				blk_raddr  = (cnt_q == 6'd8) ? 4'd1 : 4'd0;
				ctrl.wpush    = (cnt_q == 6'd8);
				ctrl.wsel_mem = 1'b1;
				ctrl.kidx     = 6'd0;
			end
			ST_ROUND: begin
				ctrl.round    = 1'b1;
				ctrl.wpush    = (cnt_q != 6'd63);
				ctrl.wsel_mem = (cnt_q < 6'd15);
				ctrl.kidx     = cnt_q + 6'd1;
				blk_re        = (cnt_q < 6'd14);
				blk_raddr     = cnt_q[3:0] + 4'd2;
			end
			ST_ADD: begin
				h_re       = (cnt_q < 6'd8);
				h_we       = (cnt_q != 6'd0);
				ctrl.shift = (cnt_q != 6'd0);
			end
			ST_OUT: begin
				h_re = !rd_pend_q && (cnt_q[3:0] < 4'd8);
			end
			default: begin
			end
		endcase
	end

	sbh_ram #(
		.WIDTH(32),
		.DEPTH(16)
	) u_blk_ram (
		.clk   (clk),
		.we    (blk_we),
		.waddr (fill_q[5:2]),
		.wdata ({word_q, push_byte}),
		.re    (blk_re),
		.raddr (blk_raddr),
		.rdata (blk_rdata)
	);

	sbh_ram #(
		.WIDTH(32),
		.DEPTH(8)
	) u_hash_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (cnt_m1),
		.wdata (h_wdata),
		.re    (h_re),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	sbh_core u_core (
		.clk       (clk),
		.ctrl      (ctrl),
		.load_word (load_word),
		.blk_word  (blk_rdata),
		.v0        (v0)
	);

	always_ff @(posedge clk) begin
		if (push_en) begin
			word_q <= {word_q[15:0], push_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_ABSORB;
			cnt_q         <= '0;
			fill_q        <= '0;
			count_q       <= '0;
			pad_q         <= 1'b0;
			pad_first_q   <= 1'b0;
			len_ok_q      <= 1'b0;
			pad_done_q    <= 1'b0;
			first_block_q <= 1'b1;
			rd_pend_q     <= 1'b0;
		end else begin
			if (push_en) begin
				fill_q <= fill_q + 6'd1;
			end
			case (state_q)
				ST_ABSORB: begin
					if (accept) begin
						if (byte_present) begin
							count_q <= count_q + 61'd1;
						end
						if (last) begin
							pad_q       <= 1'b1;
							pad_first_q <= 1'b1;
						end
						if (byte_present && (fill_q == 6'd63)) begin
							state_q <= ST_LOAD;
							cnt_q   <= '0;
						end else if (last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pad_first_q <= 1'b0;
					if (pad_first_q && (fill_q < sbh_pkg::LEN_START)) begin
						len_ok_q <= 1'b1;
					end
					if (fill_q == 6'd63) begin
						if (len_phase) begin
							pad_done_q <= 1'b1;
						end
						state_q <= ST_LOAD;
						cnt_q   <= '0;
					end
				end
				ST_LOAD: begin
					if (cnt_q == 6'd8) begin
						state_q <= ST_ROUND;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_ROUND: begin
					if (cnt_q == 6'd63) begin
						state_q <= ST_ADD;
					end
					cnt_q <= cnt_q + 6'd1;
				end
				ST_ADD: begin
					if (cnt_q == 6'd8) begin
						first_block_q <= 1'b0;
						cnt_q         <= '0;
						if (pad_done_q) begin
							state_q <= ST_OUT;
						end else if (pad_q) begin
							// a padding block follows the one just compressed
							len_ok_q <= 1'b1;
							state_q  <= ST_PAD;
						end else begin
							state_q <= ST_ABSORB;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_OUT: begin
					if (h_re) begin
						rd_pend_q <= 1'b1;
						cnt_q     <= cnt_q + 6'd1;
					end
					if (load_out) begin
						rd_pend_q <= 1'b0;
						if (cnt_q[3]) begin
							// digest out: start over for the next message
							state_q       <= ST_ABSORB;
							count_q       <= '0;
							pad_q         <= 1'b0;
							len_ok_q      <= 1'b0;
							pad_done_q    <= 1'b0;
							first_block_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_ABSORB;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			digest_word_q <= h_rdata;
			word_index_q  <= cnt_m1;
			digest_last_q <= cnt_q[3];
		end
	end

	assign out_valid   = out_valid_q;
	assign digest_word = digest_word_q;
	assign word_index  = word_index_q;
	assign digest_last = digest_last_q;

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && digest_last_q |-> word_index_q == 3'd7)
		else $error("final digest beat without index seven");

	a_blk_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		blk_we |-> (state_q == ST_ABSORB) || (state_q == ST_PAD))
		else $error("block buffer written during compression");

	a_out_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_OUT) |-> fill_q == 6'd0)
		else $error("digest started with a partial block");

	a_len_order: assert property (@(posedge clk) disable iff (!arst_n)
		pad_done_q |-> len_ok_q && pad_q)
		else $error("length written before padding allowed it");

endmodule

// ===== rtl/sbh_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module sbh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/sbh_core.sv =====
// Round unit: working variables, rolling message schedule and W+K lookahead.
`timescale 1ns / 1ps
module sbh_core (
	input  logic               clk,
	input  sbh_pkg::core_ctrl_t ctrl,
	input  logic [31:0]        load_word,
	input  logic [31:0]        blk_word,
	output logic [31:0]        v0
);

	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [31:0] wk_q;
	logic [31:0] sched;
	logic [31:0] w_next;
	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] a_new;

	always_comb begin
		sched  = w_q[0] + sbh_pkg::small_s0(w_q[1]) + w_q[9] + sbh_pkg::small_s1(w_q[14]);
		w_next = ctrl.wsel_mem ? blk_word : sched;
		ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1     = v_q[7] + sbh_pkg::big_s1(v_q[4]) + ch + wk_q;
		a_new  = t1 + sbh_pkg::big_s0(v_q[0]) + maj;
	end

	always_ff @(posedge clk) begin
		if (ctrl.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= a_new;
		end else if (ctrl.shift) begin
			// rotate for write-back, or shift a hash word in during load
			for (int i = 0; i < 7; i++) begin
				v_q[i] <= v_q[i+1];
			end
			v_q[7] <= ctrl.vload ? load_word : v_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wpush) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_next;
			wk_q    <= w_next + sbh_pkg::round_k(ctrl.kidx);
		end
	end

	assign v0 = v_q[0];

endmodule
